FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/bpl_pkg.sv
// ---------------------------------------------------------------------------
// bpl_pkg
// Types and constants of the bounded positional list.
// ---------------------------------------------------------------------------
package bpl_pkg;

    localparam int BPL_DEPTH = 16;
    localparam int DATA_W    = 32;

    typedef enum logic [2:0] {
        KIND_INS_FRONT = 3'd0,
        KIND_INS_BACK  = 3'd1,
        KIND_REM_FRONT = 3'd2,
        KIND_REM_BACK  = 3'd3,
        KIND_REM_POS   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SHIFT
    } t_state;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] value;
        logic [3:0]         position;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] removed_value;
        logic [4:0]         list_length;
    } t_rsp;

endpackage

FILE: sv/bounded_positional_list_top.sv
// ---------------------------------------------------------------------------
// bounded_positional_list_top
// Ordered list of signed 32-bit values held in a circular RAM buffer.
// ---------------------------------------------------------------------------
// The list lives in one RAM of P_DEPTH words addressed as a ring from a head
// pointer, so inserts at either end and removal of the front or back need no
// data movement. Inserts, and every request that ends in an error status or
// carries an unused kind, finish in the accept cycle. Remove front and
// remove back push their result from S_READ, after the registered RAM read.
// Remove at position reads the same way; then, in S_SHIFT, the entries
// behind the hole move forward one per cycle through the single read and
// write port pair. No new request is accepted until the list is settled.
// Two result registers sit at the output: while the first waits on a stall,
// the second takes the result of one more request, and further requests
// hold until it drains.
// Entries never written are never read, so no clearing pass runs after reset.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_positional_list_top #(
    parameter int P_DEPTH = bpl_pkg::BPL_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  bpl_pkg::t_req i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output bpl_pkg::t_rsp o_out
);

    localparam int AW = $clog2(P_DEPTH);
    localparam int CW = $clog2(P_DEPTH + 1);
    localparam int LW = (CW > 5) ? CW : 5;
    localparam int MW = (CW > 4) ? CW : 4;

    bpl_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_idx, n_idx;
    logic [AW-1:0]   r_last, n_last;
    logic            r_shift, n_shift;
    logic            r_out_valid, n_out_valid;
    bpl_pkg::t_rsp   r_out, n_out;
    logic            r_skid_valid, n_skid_valid;
    bpl_pkg::t_rsp   r_skid, n_skid;

    logic                      w_in_acc;
    logic                      w_full;
    logic                      w_empty;
    logic                      w_out_free;
    logic                      w_push;
    bpl_pkg::t_rsp             w_push_rsp;
    logic                      w_wr_en;
    logic [AW-1:0]             w_wr_addr;
    logic [bpl_pkg::DATA_W-1:0] w_wr_data;
    logic                      w_rd_en;
    logic [AW-1:0]             w_rd_addr;
    logic [bpl_pkg::DATA_W-1:0] w_rd_data;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [AW:0]   off);
        logic [AW+1:0] s;
        s = (AW+2)'(head) + (AW+2)'(off);
        if (s >= (AW+2)'(P_DEPTH)) begin
            s = s - (AW+2)'(P_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [4:0] f_len(input logic [CW-1:0] cnt);
        logic [LW-1:0] e;
        e = LW'(cnt);
        return e[4:0];
    endfunction

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != bpl_pkg::S_IDLE) || r_skid_valid;
    assign w_full     = (r_count == CW'(P_DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_count      = r_count;
        n_idx        = r_idx;
        n_last       = r_last;
        n_shift      = r_shift;
        w_push       = 1'b0;
        w_push_rsp   = '0;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_head;
        w_wr_data    = i_in.value;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_head;
        unique case (r_state)
            bpl_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    w_push                   = 1'b1;
                    w_push_rsp.status        = bpl_pkg::ST_OK;
                    w_push_rsp.removed_value = '0;
                    w_push_rsp.list_length   = f_len(r_count);
                    unique case (i_in.kind)
                        bpl_pkg::KIND_INS_FRONT, bpl_pkg::KIND_INS_BACK: begin
                            if (w_full) begin
                                w_push_rsp.status = bpl_pkg::ST_FULL;
                            end else begin
                                w_wr_en = 1'b1;
                                if (i_in.kind == bpl_pkg::KIND_INS_FRONT) begin
                                    n_head = (r_head == '0) ? AW'(P_DEPTH - 1)
                                                            : r_head - AW'(1);
                                    w_wr_addr = n_head;
                                end else begin
                                    w_wr_addr = f_phys(r_head, (AW+1)'(r_count));
                                end
                                n_count                = r_count + CW'(1);
                                w_push_rsp.list_length = f_len(n_count);
                            end
                        end
                        bpl_pkg::KIND_REM_FRONT, bpl_pkg::KIND_REM_BACK,
                        bpl_pkg::KIND_REM_POS: begin
                            if (w_empty) begin
                                w_push_rsp.status = bpl_pkg::ST_EMPTY;
                            end else if (i_in.kind == bpl_pkg::KIND_REM_POS &&
                                         MW'(i_in.position) >= MW'(r_count)) begin
                                w_push_rsp.status = bpl_pkg::ST_RANGE;
                            end else begin
                                w_push      = 1'b0;
                                n_state     = bpl_pkg::S_READ;
                                n_count     = r_count - CW'(1);
                                n_last      = AW'(r_count - CW'(1));
                                n_shift     = (i_in.kind == bpl_pkg::KIND_REM_POS);
                                w_rd_en     = 1'b1;
                                unique case (i_in.kind)
                                    bpl_pkg::KIND_REM_FRONT: begin
                                        n_idx  = '0;
                                        n_head = f_phys(r_head, (AW+1)'(1));
                                    end
                                    bpl_pkg::KIND_REM_BACK: begin
                                        n_idx = AW'(r_count - CW'(1));
                                    end
                                    default: begin
                                        n_idx = AW'(i_in.position);
                                    end
                                endcase
                                w_rd_addr = f_phys(r_head, (AW+1)'(n_idx));
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            bpl_pkg::S_READ: begin
                w_push                   = 1'b1;
                w_push_rsp.status        = bpl_pkg::ST_OK;
                w_push_rsp.removed_value = w_rd_data;
                w_push_rsp.list_length   = f_len(r_count);
                if (r_shift && r_idx != r_last) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = f_phys(r_head, (AW+1)'(r_idx) + (AW+1)'(1));
                    n_state   = bpl_pkg::S_SHIFT;
                end else begin
                    n_state = bpl_pkg::S_IDLE;
                end
            end
            bpl_pkg::S_SHIFT: begin
                w_wr_en   = 1'b1;
                w_wr_addr = f_phys(r_head, (AW+1)'(r_idx));
                w_wr_data = w_rd_data;
                if ((AW+1)'(r_idx) + (AW+1)'(1) == (AW+1)'(r_last)) begin
                    n_state = bpl_pkg::S_IDLE;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = f_phys(r_head, (AW+1)'(r_idx) + (AW+1)'(2));
                    n_idx     = r_idx + AW'(1);
                end
            end
            default: begin
                n_state = bpl_pkg::S_IDLE;
            end
        endcase

        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (w_out_free) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = w_push;
                n_skid       = w_push_rsp;
            end else begin
                n_out_valid  = w_push;
                n_out        = w_push_rsp;
            end
        end else if (w_push) begin
            n_skid_valid = 1'b1;
            n_skid       = w_push_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bpl_pkg::S_IDLE;
            r_head       <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_count      <= n_count;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_last  <= n_last;
        r_shift <= n_shift;
        r_out   <= n_out;
        r_skid  <= n_skid;
    end

    bpl_ram #(
        .P_WIDTH (bpl_pkg::DATA_W),
        .P_DEPTH (P_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CW'(P_DEPTH))
    `ASSERT_IMPL(a_shift_no_overlap, r_state == bpl_pkg::S_SHIFT && w_rd_en, w_rd_addr != w_wr_addr)
    `ASSERT_IMPL(a_read_slot_free, r_state == bpl_pkg::S_READ, !r_skid_valid)
    `ASSERT_IMPL(a_skid_behind_out, r_skid_valid, r_out_valid)
    `ASSERT_NEXT(a_shift_in_range, r_state == bpl_pkg::S_SHIFT && w_rd_en, r_idx < r_last)

endmodule

FILE: sv/bpl_ram.sv
// ---------------------------------------------------------------------------
// bpl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module bpl_ram #(
    parameter int P_WIDTH = 32,
    parameter int P_DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(P_DEPTH)-1:0] i_wr_addr,
    input  logic [P_WIDTH-1:0]         i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(P_DEPTH)-1:0] i_rd_addr,
    output logic [P_WIDTH-1:0]         o_rd_data
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
